FILE: hdl/ame_pkg.sv
// shared constants, opcodes and item types for the accumulator machine executor
package ame_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = $clog2(MEM_WORDS);
    localparam int OP_BITS   = 4;
    localparam int CNT_BITS  = 2;
    localparam int SEL_BITS  = 3;

    localparam logic [OP_BITS-1:0] OP_SET = 4'd0;
    localparam logic [OP_BITS-1:0] OP_ADD = 4'd1;
    localparam logic [OP_BITS-1:0] OP_SUB = 4'd2;
    localparam logic [OP_BITS-1:0] OP_MUL = 4'd3;
    localparam logic [OP_BITS-1:0] OP_DIV = 4'd4;
    localparam logic [OP_BITS-1:0] OP_INC = 4'd5;
    localparam logic [OP_BITS-1:0] OP_DEC = 4'd6;
    localparam logic [OP_BITS-1:0] OP_MOV = 4'd7;
    localparam logic [OP_BITS-1:0] OP_LDR = 4'd8;
    localparam logic [OP_BITS-1:0] OP_STR = 4'd9;
    localparam logic [OP_BITS-1:0] OP_BEQ = 4'd10;
    localparam logic [OP_BITS-1:0] OP_AND = 4'd11;
    localparam logic [OP_BITS-1:0] OP_OR  = 4'd12;
    localparam logic [OP_BITS-1:0] OP_SHW = 4'd13;

    localparam logic [SEL_BITS-1:0] SEL_ACC = 3'd0;
    localparam logic [SEL_BITS-1:0] SEL_MAR = 3'd1;
    localparam logic [SEL_BITS-1:0] SEL_MDR = 3'd2;
    localparam logic [SEL_BITS-1:0] SEL_OPC = 3'd3;
    localparam logic [SEL_BITS-1:0] SEL_MEM = 3'd4;

    localparam logic [CNT_BITS-1:0] CNT_TWO   = 2'd2;
    localparam logic [CNT_BITS-1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]          mode;
        logic [ADDR_BITS-1:0]        addr_a;
        logic [ADDR_BITS-1:0]        addr_b;
        logic [ADDR_BITS-1:0]        addr_c;
        logic [CNT_BITS-1:0]         operand_count;
        logic signed [DATA_BITS-1:0] imm_value;
        logic [SEL_BITS-1:0]         show_sel;
    } ame_in_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] acc_out;
        logic [ADDR_BITS-1:0]        mar_out;
        logic signed [DATA_BITS-1:0] mdr_out;
        logic [OP_BITS-1:0]          last_opcode;
        logic signed [DATA_BITS-1:0] shown_value;
    } ame_out_t;

endpackage

FILE: hdl/ame_in_if.sv
// valid/ready channel carrying instruction items
interface ame_in_if;
    import ame_pkg::*;

    logic    valid;
    logic    ready;
    ame_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ame_out_if.sv
// valid/ready channel carrying result items
interface ame_out_if;
    import ame_pkg::*;

    logic     valid;
    logic     ready;
    ame_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/accumulator_machine_executor_unit.sv
// accumulator machine executor: sequencer around a single-port data memory
//
// Channels: cmd takes one instruction item (opcode, three word addresses,
// operand count, immediate, show source); res gives one result item per
// instruction (accumulator, MAR, MDR, last opcode, last shown value).
// Both use valid/ready; an item moves when valid and ready are high at a
// rising edge of clk.
// After its instruction is accepted, the unit reads the second operand
// (S_RDB), then the first operand (S_RDA) and executes (S_EXEC) on the
// memory's single port, then the write-back state S_WR also loads the
// result register. The single read/write port sets this sequence; a new
// item is accepted in the cycle after the result is loaded, and not
// before the last item is through.
// The result register keeps the item until res.ready; while it is still
// full, the write-back cycle waits and cmd.ready stays low.
// Reset (rst_n low, asynchronous) clears the accumulator, MAR, MDR, opcode
// and shown registers, then a clearing pass writes each of the 1024 data
// words with its own index; cmd.ready stays low during that pass.
module accumulator_machine_executor_unit (
    input  logic          clk,
    input  logic          rst_n,
    ame_in_if.sink        cmd,
    ame_out_if.source     res
);
    import ame_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;

    logic [DATA_BITS-1:0] mem [MEM_WORDS];
    logic [DATA_BITS-1:0] mem_q;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [DATA_BITS-1:0] mem_wdata;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    ame_out_t             out_data_reg, out_data_next;
    ame_in_t              ins_reg, ins_next;

    logic [DATA_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] mar_reg, mar_next;
    logic [DATA_BITS-1:0] mdr_reg, mdr_next;
    logic [OP_BITS-1:0]   ctrl_reg, ctrl_next;
    logic [DATA_BITS-1:0] shown_reg, shown_next;
    logic [DATA_BITS-1:0] bval_reg, bval_next;

    logic                 two_src;
    logic [DATA_BITS-1:0] other;
    logic [DATA_BITS-1:0] product;
    logic [DATA_BITS-1:0] arith;

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // single-port memory, read-first
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    assign two_src = (ins_reg.operand_count == CNT_TWO) || (ins_reg.operand_count == CNT_THREE);
    assign other   = two_src ? bval_reg : acc_reg;
    assign product = mem_q * other;

    always_comb
    begin
        case (ins_reg.mode)
            OP_ADD:  arith = mem_q + other;
            OP_SUB:  arith = mem_q - other;
            OP_MUL:  arith = (!other[DATA_BITS-1] && (other > DATA_BITS'(1))) ? product : mem_q;
            default: arith = mem_q;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ins_next       = ins_reg;
        acc_next       = acc_reg;
        mar_next       = mar_reg;
        mdr_next       = mdr_reg;
        ctrl_next      = ctrl_reg;
        shown_next     = shown_reg;
        bval_next      = bval_reg;
        mem_we         = 1'b0;
        mem_addr       = ins_reg.addr_a;
        mem_wdata      = acc_reg;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = DATA_BITS'(clr_reg);
                clr_next  = clr_reg + ADDR_BITS'(1);
                if (clr_reg == ADDR_BITS'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    ins_next   = cmd.data;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                mem_addr   = ins_reg.addr_b;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                bval_next  = mem_q;
                mem_addr   = ins_reg.addr_a;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_WR;
                ctrl_next  = ins_reg.mode;
                case (ins_reg.mode)
                    OP_SET:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = ins_reg.imm_value;
                        mar_next  = ins_reg.addr_a;
                        mdr_next  = ins_reg.imm_value;
                    end
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        acc_next = arith;
                        if (ins_reg.operand_count == CNT_THREE)
                        begin
                            mar_next = ins_reg.addr_c;
                            mdr_next = arith;
                        end
                        else
                        begin
                            mar_next = ins_reg.addr_a;
                            mdr_next = mem_q;
                        end
                    end
                    OP_INC, OP_DEC:
                    begin
                        acc_next = (ins_reg.mode == OP_INC) ? mem_q + DATA_BITS'(1)
                                                            : mem_q - DATA_BITS'(1);
                        mar_next = ins_reg.addr_a;
                        mdr_next = acc_next;
                    end
                    OP_MOV:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = ins_reg.addr_b;
                        mem_wdata = mem_q;
                        acc_next  = mem_q;
                        mar_next  = ins_reg.addr_a;
                        mdr_next  = '0;
                    end
                    OP_LDR:
                    begin
                        acc_next = mem_q;
                        mar_next = ins_reg.addr_a;
                        mdr_next = mem_q;
                    end
                    OP_STR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = acc_reg;
                        mar_next  = ins_reg.addr_a;
                        mdr_next  = acc_reg;
                    end
                    OP_SHW:
                    begin
                        case (ins_reg.show_sel)
                            SEL_ACC: shown_next = acc_reg;
                            SEL_MAR: shown_next = DATA_BITS'(mar_reg);
                            SEL_MDR: shown_next = mdr_reg;
                            SEL_OPC: shown_next = DATA_BITS'(ctrl_reg);
                            SEL_MEM: shown_next = mem_q;
                            default: shown_next = shown_reg;
                        endcase
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            S_WR:
            begin
                case (ins_reg.mode)
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        mem_we   = (ins_reg.operand_count == CNT_THREE);
                        mem_addr = ins_reg.addr_c;
                    end
                    OP_INC, OP_DEC:
                    begin
                        mem_we = 1'b1;
                    end
                    OP_MOV:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '0;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.acc_out     = acc_reg;
                    out_data_next.mar_out     = mar_reg;
                    out_data_next.mdr_out     = mdr_reg;
                    out_data_next.last_opcode = ctrl_reg;
                    out_data_next.shown_value = shown_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            mar_reg       <= '0;
            mdr_reg       <= '0;
            ctrl_reg      <= '0;
            shown_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            mar_reg       <= mar_next;
            mdr_reg       <= mdr_next;
            ctrl_reg      <= ctrl_next;
            shown_reg     <= shown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg      <= ins_next;
        bval_reg     <= bval_next;
        out_data_reg <= out_data_next;
    end

endmodule
